@@ rtl/lpto_pkg.sv @@
// ----------------------------------------------------------------------------
// lpto_pkg
// Shared widths, constants and types for the LIFO preemptive task order block.
// ----------------------------------------------------------------------------
package lpto_pkg;

	localparam int unsigned LPTO_STACK_DEPTH = 32;

	localparam int unsigned ID_W   = 10;
	localparam int unsigned TIME_W = 11;
	localparam int unsigned DUR_W  = 10;

	// Write request into the task stack
	typedef struct packed {
		logic             we;
		logic [ID_W-1:0]  task_id;
		logic [DUR_W-1:0] remaining;
	} lpto_wr_t;

	// Read data out of the task stack
	typedef struct packed {
		logic [ID_W-1:0]  task_id;
		logic [DUR_W-1:0] remaining;
	} lpto_entry_t;

	// Result of the shared time unit
	typedef struct packed {
		logic              fits;
		logic [DUR_W-1:0]  rem_left;
		logic [TIME_W-1:0] time_next;
	} lpto_alu_res_t;

endpackage

@@ rtl/lpto_if.sv @@
// ----------------------------------------------------------------------------
// lpto_if
// Valid/ready channels for task arrivals and finished-task reports.
// ----------------------------------------------------------------------------
interface lpto_task_if;
	import lpto_pkg::*;

	logic              valid;
	logic              ready;
	logic [ID_W-1:0]   task_id;
	logic [TIME_W-1:0] start_minute;
	logic [DUR_W-1:0]  duration;
	logic              final_task;

	modport source (output valid, task_id, start_minute, duration, final_task, input ready);
	modport sink   (input valid, task_id, start_minute, duration, final_task, output ready);
endinterface

interface lpto_done_if;
	import lpto_pkg::*;

	logic            valid;
	logic            ready;
	logic [ID_W-1:0] done_id;
	logic            last_of_run;
	logic            all_done;
	logic            overflow;

	modport source (output valid, done_id, last_of_run, all_done, overflow, input ready);
	modport sink   (input valid, done_id, last_of_run, all_done, overflow, output ready);
endinterface

@@ rtl/lpto_stack.sv @@
// ----------------------------------------------------------------------------
// lpto_stack
// Task stack storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lpto_stack #(
	parameter int unsigned STACK_DEPTH = lpto_pkg::LPTO_STACK_DEPTH,
	parameter int unsigned AW          = $clog2(STACK_DEPTH)
) (
	input  logic                 clk,
	input  lpto_pkg::lpto_wr_t   wr,
	input  logic [AW-1:0]        wr_addr,
	input  logic [AW-1:0]        rd_addr,
	output lpto_pkg::lpto_entry_t rd_data
);
	import lpto_pkg::*;

	lpto_entry_t mem_q [STACK_DEPTH];
	lpto_entry_t rd_q;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem_q[wr_addr] <= '{task_id: wr.task_id, remaining: wr.remaining};
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_q;

endmodule

@@ rtl/lpto_alu.sv @@
// ----------------------------------------------------------------------------
// lpto_alu
// Shared time unit: elapsed time, finish test, remainder and advanced clock.
// ----------------------------------------------------------------------------
module lpto_alu (
	input  logic [lpto_pkg::TIME_W-1:0] start_minute,
	input  logic [lpto_pkg::TIME_W-1:0] cur_time,
	input  logic [lpto_pkg::DUR_W-1:0]  remaining,
	output lpto_pkg::lpto_alu_res_t     res
);
	import lpto_pkg::*;

	logic [TIME_W-1:0] elapsed;

	// Clamp a start that lies before the charged time to zero elapsed
	assign elapsed = (start_minute >= cur_time) ? (start_minute - cur_time) : '0;

	assign res.fits      = ({1'b0, remaining} <= elapsed);
	assign res.rem_left  = remaining - elapsed[DUR_W-1:0];
	assign res.time_next = cur_time + {1'b0, remaining};

endmodule

@@ rtl/lifo_preemptive_task_order.sv @@
// ----------------------------------------------------------------------------
// lifo_preemptive_task_order
// Preemptive task scheduler with a LIFO stack of interrupted tasks.
// ----------------------------------------------------------------------------
// Tasks arrive on 'arrival' in nondecreasing start order; each one preempts
// the running task, which waits on a stack with its remaining minutes. On an
// arrival the block pops and reports, most recent first, every stacked task
// that finishes by the new start, charges the elapsed time to the first one
// that does not, then pushes the new task. A push onto a full stack drops the
// task and reports it with overflow set. An arrival marked final_task drains
// the whole stack in pop order and flags the last report with all_done.
// Reports leave on 'report'; last_of_run marks the final report of an arrival
// and an arrival that finishes nothing and drops nothing gives no report.
// An arrival passes through the pop and push states and, on a final task, the
// settle and drain states, before the held-back last report is flushed. The
// single time unit and the single read port of the stack together retire one
// stacked entry per cycle while 'report' does not stall them; back-pressure
// on 'report' can hold pops, drops, drains and the final flush.
// 'arrival.ready' is high only while the block is idle. No clearing pass is
// needed after reset.
// ----------------------------------------------------------------------------
module lifo_preemptive_task_order #(
	parameter int unsigned STACK_DEPTH = lpto_pkg::LPTO_STACK_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	lpto_task_if.sink    arrival,
	lpto_done_if.source  report
);
	import lpto_pkg::*;

	localparam int unsigned AW = $clog2(STACK_DEPTH);
	localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

	typedef enum logic [2:0] {
		S_IDLE,   // wait for an arrival
		S_POP,    // retire stacked tasks that finish by the new start
		S_PUSH,   // push the new task or report it as dropped
		S_SETTLE, // let the stack read port catch up with the push
		S_DRAIN,  // empty the stack on a final task
		S_FLUSH   // hand out the held-back last report
	} state_t;

	state_t state_q, state_d;

	logic [CW-1:0]     count_q, count_d;
	logic [TIME_W-1:0] cur_q, cur_d;

	// Captured arrival
	logic [ID_W-1:0]   id_q, id_d;
	logic [TIME_W-1:0] start_q, start_d;
	logic [DUR_W-1:0]  dur_q, dur_d;
	logic              fin_q, fin_d;

	// One report is held back so its last_of_run flag can be decided
	logic              pend_valid_q, pend_valid_d;
	logic [ID_W-1:0]   pend_id_q, pend_id_d;
	logic              pend_ovf_q, pend_ovf_d;

	// Output register
	logic              out_valid_q, out_valid_d;
	logic [ID_W-1:0]   out_id_q, out_id_d;
	logic              out_last_q, out_last_d;
	logic              out_all_q, out_all_d;
	logic              out_ovf_q, out_ovf_d;

	logic              out_busy;
	logic              stall;
	logic              emit;
	logic [ID_W-1:0]   emit_id;
	logic              emit_ovf;

	lpto_wr_t          wr;
	logic [AW-1:0]     wr_addr;
	logic [AW-1:0]     rd_addr;
	lpto_entry_t       rd_data;
	lpto_alu_res_t     alu;

	lpto_stack #(
		.STACK_DEPTH (STACK_DEPTH),
		.AW          (AW)
	) u_stack (
		.clk     (clk),
		.wr      (wr),
		.wr_addr (wr_addr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	lpto_alu u_alu (
		.start_minute (start_q),
		.cur_time     (cur_q),
		.remaining    (rd_data.remaining),
		.res          (alu)
	);

	// Prefetch the entry that will be on top next cycle
	assign rd_addr = (count_d == '0) ? '0 : AW'(count_d - CW'(1));

	assign out_busy = out_valid_q && !report.ready;
	// A new report needs the held one to move into a free output register
	assign stall    = pend_valid_q && out_busy;

	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		cur_d        = cur_q;
		id_d         = id_q;
		start_d      = start_q;
		dur_d        = dur_q;
		fin_d        = fin_q;
		pend_valid_d = pend_valid_q;
		pend_id_d    = pend_id_q;
		pend_ovf_d   = pend_ovf_q;
		out_valid_d  = out_valid_q;
		out_id_d     = out_id_q;
		out_last_d   = out_last_q;
		out_all_d    = out_all_q;
		out_ovf_d    = out_ovf_q;
		emit         = 1'b0;
		emit_id      = rd_data.task_id;
		emit_ovf     = 1'b0;
		wr.we        = 1'b0;
		wr.task_id   = id_q;
		wr.remaining = alu.rem_left;
		wr_addr      = AW'(count_q - CW'(1));

		// Retire the output transaction once taken
		if (out_valid_q && report.ready) begin
			out_valid_d = 1'b0;
		end

		case (state_q)
			S_IDLE: begin
				if (arrival.valid) begin
					id_d    = arrival.task_id;
					start_d = arrival.start_minute;
					dur_d   = arrival.duration;
					fin_d   = arrival.final_task;
					state_d = S_POP;
				end
			end
			S_POP: begin
				if (count_q == '0) begin
					state_d = S_PUSH;
				end else if (alu.fits) begin
					if (!stall) begin
						emit    = 1'b1;
						cur_d   = alu.time_next;
						count_d = count_q - CW'(1);
					end
				end else begin
					// Charge the elapsed time to the top task and stop
					wr.we      = 1'b1;
					wr.task_id = rd_data.task_id;
					state_d    = S_PUSH;
				end
			end
			S_PUSH: begin
				cur_d = start_q;
				if (count_q == DEPTH_C) begin
					if (!stall) begin
						emit     = 1'b1;
						emit_id  = id_q;
						emit_ovf = 1'b1;
						state_d  = fin_q ? S_SETTLE : S_FLUSH;
					end
				end else begin
					wr.we        = 1'b1;
					wr.remaining = dur_q;
					wr_addr      = AW'(count_q);
					count_d      = count_q + CW'(1);
					state_d      = fin_q ? S_SETTLE : S_FLUSH;
				end
			end
			S_SETTLE: begin
				state_d = S_DRAIN;
			end
			S_DRAIN: begin
				if (count_q == '0) begin
					state_d = S_FLUSH;
				end else if (!stall) begin
					emit    = 1'b1;
					count_d = count_q - CW'(1);
				end
			end
			S_FLUSH: begin
				if (!pend_valid_q) begin
					state_d = S_IDLE;
				end else if (!out_busy) begin
					out_valid_d  = 1'b1;
					out_id_d     = pend_id_q;
					out_ovf_d    = pend_ovf_q;
					out_last_d   = 1'b1;
					out_all_d    = fin_q;
					pend_valid_d = 1'b0;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// Advance the held report to the output and hold the new one back
		if (emit) begin
			if (pend_valid_q) begin
				out_valid_d = 1'b1;
				out_id_d    = pend_id_q;
				out_ovf_d   = pend_ovf_q;
				out_last_d  = 1'b0;
				out_all_d   = 1'b0;
			end
			pend_valid_d = 1'b1;
			pend_id_d    = emit_id;
			pend_ovf_d   = emit_ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			cur_q        <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			count_q      <= count_d;
			cur_q        <= cur_d;
			pend_valid_q <= pend_valid_d;
			out_valid_q  <= out_valid_d;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		id_q      <= id_d;
		start_q   <= start_d;
		dur_q     <= dur_d;
		fin_q     <= fin_d;
		pend_id_q <= pend_id_d;
		pend_ovf_q <= pend_ovf_d;
		out_id_q  <= out_id_d;
		out_last_q <= out_last_d;
		out_all_q <= out_all_d;
		out_ovf_q <= out_ovf_d;
	end

	assign arrival.ready      = (state_q == S_IDLE);
	assign report.valid       = out_valid_q;
	assign report.done_id     = out_id_q;
	assign report.last_of_run = out_last_q;
	assign report.all_done    = out_all_q;
	assign report.overflow    = out_ovf_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("stack count beyond depth");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		arrival.ready |-> !pend_valid_q)
		else $error("held report left behind while idle");

	a_drain_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DRAIN && count_q != '0 && !stall)
		|=> count_q == $past(count_q) - CW'(1))
		else $error("drain did not retire one entry");

	a_all_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_all_q) |-> out_last_q)
		else $error("all_done without last_of_run");

	a_drain_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DRAIN && state_d == S_FLUSH) |-> count_q == '0)
		else $error("drain left entries on the stack");
`endif

endmodule
